FILE: rtl/sbl_pkg.sv
package sbl_pkg;

   // Build-time defaults
   localparam int unsigned MaxWidthDefault = 2048;
   localparam int unsigned StoreRows       = 4;

   // Register reset values
   localparam logic [11:0] WidthReset  = 12'd640;
   localparam logic [11:0] HeightReset = 12'd480;

   // Register indexes on the csr port
   typedef enum logic [0:0] {
      CSR_FRAME_WIDTH  = 1'b0,
      CSR_FRAME_HEIGHT = 1'b1
   } csr_index_type;

   // Item kinds carried in tuser
   localparam logic MODE_PIXEL = 1'b0;
   localparam logic MODE_DRAIN = 1'b1;

   typedef logic [23:0] pixel_type;

   // 1-2-4-2-1 weighted sum of five 8-bit taps, at most 2550
   function automatic logic [11:0] tap_sum(input logic [7:0] t0, input logic [7:0] t1,
                                           input logic [7:0] t2, input logic [7:0] t3,
                                           input logic [7:0] t4);
      return {4'b0, t0} + {3'b0, t1, 1'b0} + {2'b0, t2, 2'b0} + {3'b0, t3, 1'b0} + {4'b0, t4};
   endfunction

   // Truncating divide by ten, exact for sums up to 2550 (reciprocal 1639 / 2^14)
   function automatic logic [7:0] div10(input logic [11:0] sum);
      logic [22:0] prod;
      prod = {11'b0, sum} * 23'd1639;
      return prod[21:14];
   endfunction

endpackage

FILE: rtl/sbl_ram.sv
module sbl_ram #(
   parameter int unsigned WIDTH = 24,
   parameter int unsigned DEPTH = 2048,
   localparam int unsigned AddrW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AddrW-1:0] waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic             re,
   input  logic [AddrW-1:0] raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Simple dual port, read-first on a same-address collision
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

FILE: rtl/separable_blur_5x5_top.sv
// Separable 5x5 1-2-4-2-1 blur of a raster-order three-channel 8-bit stream.
// req channel: one item per pixel, tdata = {red, green, blue}, tuser = 1 marks a
// drain item. Drain items are ignored until the last pixel of the frame has gone
// in; after that they (and any further items) flush the remaining results.
// rsp channel: one blurred pixel per result, tlast marks the end of a row and
// tuser the end of the frame. The result for pixel n is produced by the item
// that carries pixel n + 2*width + 2 (or the drain item in its place), and
// goes from stage 1 through stage 2 into the rsp registers.
// Throughput is one item per clock: the four line-store banks each take one
// read and one write per cycle, and the whole datapath is a three-stage pipe.
// When the receiver stalls with a result held, req_tready drops and the pipe
// holds; an item is still taken in any cycle in which the held result leaves.
// Reset sets the frame to 640x480 (width clamped to MAX_WIDTH) and zeroes the
// position counters. The line store is not cleared: rows outside the frame get
// zero weight, so stale contents never reach a result. A csr write restarts
// the frame.
module separable_blur_5x5_top #(
   parameter int unsigned MAX_WIDTH = sbl_pkg::MaxWidthDefault
) (
   input  logic                  clock,
   input  logic                  reset,
   // req_tdata: blue_in [7:0], green_in [15:8], red_in [23:16]
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [23:0]           req_tdata,
   // req_tuser: mode
   input  logic                  req_tuser,
   // rsp_tdata: blue_out [7:0], green_out [15:8], red_out [23:16]
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [23:0]           rsp_tdata,
   // rsp_tlast: line_end
   output logic                  rsp_tlast,
   // rsp_tuser: frame_end
   output logic                  rsp_tuser,
   input  logic                  csr_we,
   input  sbl_pkg::csr_index_type csr_addr,
   input  logic [11:0]           csr_wdata
);

   import sbl_pkg::*;

   localparam int unsigned AddrW     = $clog2(MAX_WIDTH);
   localparam logic [12:0] MaxWidthV = 13'(MAX_WIDTH);
   localparam logic [11:0] WidthInit = (MAX_WIDTH < 640) ? 12'(MAX_WIDTH) : WidthReset;

   // Frame geometry, kept in effective (clamped) form
   logic [11:0] w_ff, h_ff;
   logic [13:0] lag_ff;
   logic [11:0] eff_w;

   // Position counters
   logic [11:0] in_col_ff, in_col_in;
   logic [12:0] in_row_ff, in_row_in;
   logic [13:0] qc_ff, qc_in;
   logic [11:0] out_col_ff, out_col_in;
   logic [11:0] out_row_ff, out_row_in;

   // Accept-stage decode
   logic        advance, accepted, have_pixel, process;
   logic        col_wrap, emit, out_line, out_last;
   logic [4:0]  rmask, cmask;
   logic [13:0] row_ext;
   logic [12:0] col_ext;

   // Stage 1: line-store read data is valid here
   logic        s1_valid_ff, s1_push_ff, s1_emit_ff, s1_line_ff, s1_frame_ff;
   pixel_type   s1_pix_ff;
   logic [4:0]  s1_rmask_ff, s1_cmask_ff;
   logic [1:0]  s1_slot_ff;
   pixel_type   bank_rd [StoreRows];
   pixel_type   vtap [5];
   pixel_type   vres;

   // Stage 2: vertical window holds this item's column
   logic        s2_emit_ff, s2_line_ff, s2_frame_ff;
   logic [4:0]  s2_cmask_ff;
   pixel_type   win_ff [5];
   pixel_type   hres;

   // Result register
   logic        rsp_valid_ff, rsp_last_ff, rsp_user_ff;
   pixel_type   rsp_data_ff;

   // Configuration
   always_comb begin
      if (csr_wdata == 12'd0) begin
         eff_w = 12'd1;
      end else if ({1'b0, csr_wdata} > MaxWidthV) begin
         eff_w = MaxWidthV[11:0];
      end else begin
         eff_w = csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         w_ff   <= WidthInit;
         h_ff   <= HeightReset;
         lag_ff <= {1'b0, WidthInit, 1'b0} + 14'd2;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_FRAME_WIDTH: begin
               w_ff   <= eff_w;
               lag_ff <= {1'b0, eff_w, 1'b0} + 14'd2;
            end
            CSR_FRAME_HEIGHT: begin
               h_ff <= (csr_wdata == 12'd0) ? 12'd1 : csr_wdata;
            end
         endcase
      end
   end

   // Handshake and accept-stage decode
   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = advance;
   assign accepted   = req_tvalid && advance;
   assign have_pixel = in_row_ff < {1'b0, h_ff};
   // a drain item before the frame is fully in is swallowed
   assign process    = accepted && (req_tuser == MODE_PIXEL || !have_pixel);
   assign col_wrap   = in_col_ff == (w_ff - 12'd1);
   assign emit       = qc_ff == lag_ff;
   assign out_line   = out_col_ff == (w_ff - 12'd1);
   assign out_last   = out_line && (out_row_ff == (h_ff - 12'd1));
   assign row_ext    = {1'b0, in_row_ff};
   assign col_ext    = {1'b0, out_col_ff};

   // Tap k of the vertical pass is row r-4+k, of the horizontal pass column c-2+k
   always_comb begin
      for (int k = 0; k < 5; k++) begin
         rmask[k] = (row_ext + 14'(k) >= 14'd4) &&
                    (row_ext + 14'(k) < {2'b0, h_ff} + 14'd4);
         cmask[k] = (col_ext + 13'(k) >= 13'd2) &&
                    (col_ext + 13'(k) < {1'b0, w_ff} + 13'd2);
      end
   end

   // Position counters
   always_comb begin
      in_col_in  = in_col_ff;
      in_row_in  = in_row_ff;
      qc_in      = qc_ff;
      out_col_in = out_col_ff;
      out_row_in = out_row_ff;
      if (process) begin
         if (col_wrap) begin
            in_col_in = 12'd0;
            in_row_in = in_row_ff + 13'd1;
         end else begin
            in_col_in = in_col_ff + 12'd1;
         end
         if (emit) begin
            if (out_line) begin
               out_col_in = 12'd0;
               out_row_in = out_row_ff + 12'd1;
            end else begin
               out_col_in = out_col_ff + 12'd1;
            end
         end else begin
            qc_in = qc_ff + 14'd1;
         end
         // last pixel of the frame: start over
         if (emit && out_last) begin
            in_col_in  = 12'd0;
            in_row_in  = 13'd0;
            qc_in      = 14'd0;
            out_col_in = 12'd0;
            out_row_in = 12'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || csr_we) begin
         in_col_ff  <= 12'd0;
         in_row_ff  <= 13'd0;
         qc_ff      <= 14'd0;
         out_col_ff <= 12'd0;
         out_row_ff <= 12'd0;
      end else begin
         in_col_ff  <= in_col_in;
         in_row_ff  <= in_row_in;
         qc_ff      <= qc_in;
         out_col_ff <= out_col_in;
         out_row_ff <= out_row_in;
      end
   end

   // Line store: one bank per row slot, the slot being written holds row r-4
   for (genvar b = 0; b < StoreRows; b++) begin : g_bank
      sbl_ram #(
         .WIDTH (24),
         .DEPTH (MAX_WIDTH)
      ) u_ram (
         .clock (clock),
         .we    (process && have_pixel && (in_row_ff[1:0] == 2'(b))),
         .waddr (in_col_ff[AddrW-1:0]),
         .wdata (req_tdata),
         .re    (advance),
         .raddr (in_col_ff[AddrW-1:0]),
         .rdata (bank_rd[b])
      );
   end

   // Vertical pass
   always_comb begin
      logic [1:0]  slot;
      logic [7:0]  t [5];
      logic [11:0] sum;
      for (int k = 0; k < 4; k++) begin
         slot    = s1_slot_ff + 2'(k);
         vtap[k] = bank_rd[slot];
      end
      vtap[4] = s1_pix_ff;
      for (int ch = 0; ch < 3; ch++) begin
         for (int k = 0; k < 5; k++) begin
            t[k] = s1_rmask_ff[k] ? vtap[k][8*ch +: 8] : 8'd0;
         end
         sum             = tap_sum(t[0], t[1], t[2], t[3], t[4]);
         vres[8*ch +: 8] = div10(sum);
      end
   end

   // Horizontal pass over the window
   always_comb begin
      logic [7:0]  t [5];
      logic [11:0] sum;
      for (int ch = 0; ch < 3; ch++) begin
         for (int k = 0; k < 5; k++) begin
            t[k] = s2_cmask_ff[k] ? win_ff[k][8*ch +: 8] : 8'd0;
         end
         sum             = tap_sum(t[0], t[1], t[2], t[3], t[4]);
         hres[8*ch +: 8] = div10(sum);
      end
   end

   // Pipeline valids
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_emit_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff  <= process;
         s2_emit_ff   <= s1_valid_ff && s1_emit_ff;
         rsp_valid_ff <= s2_emit_ff;
      end
   end

   // Pipeline payload
   always_ff @(posedge clock) begin
      if (advance) begin
         s1_pix_ff   <= req_tdata;
         s1_rmask_ff <= rmask;
         s1_cmask_ff <= cmask;
         s1_slot_ff  <= in_row_ff[1:0];
         s1_push_ff  <= in_row_ff >= 13'd2;
         s1_emit_ff  <= emit;
         s1_line_ff  <= out_line;
         s1_frame_ff <= out_last;

         s2_cmask_ff <= s1_cmask_ff;
         s2_line_ff  <= s1_line_ff;
         s2_frame_ff <= s1_frame_ff;

         rsp_data_ff <= hres;
         rsp_last_ff <= s2_line_ff;
         rsp_user_ff <= s2_frame_ff;

         if (s1_valid_ff && s1_push_ff) begin
            for (int k = 0; k < 4; k++) begin
               win_ff[k] <= win_ff[k+1];
            end
            win_ff[4] <= vres;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_user_ff;

   // Checks
   a_frame_end_is_line_end: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tlast)
      else $error("frame end without line end");

   a_out_col_in_frame: assert property (@(posedge clock) disable iff (reset)
      out_col_ff < w_ff)
      else $error("output column beyond frame width");

   a_in_row_bounded: assert property (@(posedge clock) disable iff (reset)
      {1'b0, in_row_ff} <= {2'b0, h_ff} + 14'd3)
      else $error("input row ran past the drain rows");

   a_cfg_restarts: assert property (@(posedge clock) disable iff (reset)
      csr_we |=> (in_col_ff == 12'd0 && in_row_ff == 13'd0 && qc_ff == 14'd0 &&
                  out_row_ff == 12'd0))
      else $error("register write did not restart the frame");

endmodule
